// ===== rtl/quoted_field_tokenizer_macros.svh =====
// Assertion helpers for the tokenizer's port-level checker.
`ifndef QUOTED_FIELD_TOKENIZER_MACROS_SVH
`define QUOTED_FIELD_TOKENIZER_MACROS_SVH

// Implication checked outside reset.
`define QFT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qft assertion failed");

// Next-cycle implication, also checked across reset.
`define QFT_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("qft assertion failed");

`endif

// ===== rtl/qft_pkg.sv =====
`default_nettype none
package qft_pkg;

   // Line limits
   localparam int MAX_FIELDS = 32;
   localparam int LINE_BYTES = 16384;

   // Widths of the result fields
   localparam int IDX_W = 5;
   localparam int POS_W = 14;

   // Internal widths: the offset must hold LINE_BYTES + 1, the count MAX_FIELDS
   localparam int OFF_W  = $clog2(LINE_BYTES + 2);
   localparam int CNT_W  = $clog2(MAX_FIELDS + 1);
   localparam int WPOS_W = (OFF_W > POS_W) ? OFF_W : POS_W;
   localparam int WIDX_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   // Byte codes
   localparam logic [7:0] QUOTE_BYTE    = 8'h22;
   localparam logic [7:0] SPACE_BYTE    = 8'h20;
   localparam logic [7:0] LINE_END_INIT = 8'h0A;

   typedef struct packed {
      logic             inside_quotes;
      logic             just_closed_quote;
      logic             error_seen;
      logic [OFF_W-1:0] byte_offset;
      logic [OFF_W-1:0] field_start;
      logic [CNT_W-1:0] fields_done;
   } state_type;

   typedef struct packed {
      logic             field_valid;
      logic [IDX_W-1:0] field_index;
      logic [POS_W-1:0] field_start;
      logic [POS_W-1:0] field_length;
      logic             line_end;
      logic             line_error;
   } result_type;

   // Fit an offset into a result position field (low bits kept)
   function automatic logic [POS_W-1:0] fit_pos(input logic [OFF_W-1:0] v);
      logic [WPOS_W-1:0] w;
      w = WPOS_W'(v);
      return w[POS_W-1:0];
   endfunction

   // Fit a field count into the result index field (low bits kept)
   function automatic logic [IDX_W-1:0] fit_idx(input logic [CNT_W-1:0] v);
      logic [WIDX_W-1:0] w;
      w = WIDX_W'(v);
      return w[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/quoted_field_tokenizer.sv =====
`default_nettype none
// An accepted byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle while no result stalls; the only loop is the line-state update.
// A result waiting for rsp_ready stalls the input register, then req_ready.
// Reset (synchronous, active high) empties the pipeline, clears the line
// state and sets the line-end byte to 0x0A.
module quoted_field_tokenizer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_line_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_field_valid,
   output logic [qft_pkg::IDX_W-1:0]      rsp_field_index,
   output logic [qft_pkg::POS_W-1:0]      rsp_field_start,
   output logic [qft_pkg::POS_W-1:0]      rsp_field_length,
   output logic                           rsp_line_end,
   output logic                           rsp_line_error,
   input  wire logic                      csr_write_enable,
   input  wire logic [7:0]                csr_write_data
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 out_valid_ff, out_valid_in;
   qft_pkg::result_type  result_ff, result_in;
   qft_pkg::state_type   state_ff, state_in;
   logic [7:0]           line_end_char_ff, line_end_char_in;
   qft_pkg::state_type   step_state;
   qft_pkg::result_type  step_result;
   logic                 out_free;
   logic                 step_go;

   // Step logic
   qft_core u_core (
      .line_byte     (in_byte_ff),
      .line_end_char (line_end_char_ff),
      .cur           (state_ff),
      .nxt           (step_state),
      .res           (step_result)
   );

   // Pipeline flow control
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_go   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in      = req_ready ? req_valid : in_valid_ff;
      in_byte_in       = (req_valid && req_ready) ? req_line_byte : in_byte_ff;
      out_valid_in     = out_free ? in_valid_ff : out_valid_ff;
      result_in        = step_go ? step_result : result_ff;
      state_in         = step_go ? step_state : state_ff;
      line_end_char_in = csr_write_enable ? csr_write_data : line_end_char_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff         <= '0;
         line_end_char_ff <= qft_pkg::LINE_END_INIT;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         state_ff         <= state_in;
         line_end_char_ff <= line_end_char_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_field_valid  = result_ff.field_valid;
   assign rsp_field_index  = result_ff.field_index;
   assign rsp_field_start  = result_ff.field_start;
   assign rsp_field_length = result_ff.field_length;
   assign rsp_line_end     = result_ff.line_end;
   assign rsp_line_error   = result_ff.line_error;

endmodule
`default_nettype wire

// ===== rtl/qft_core.sv =====
`default_nettype none
// Per-byte tokenizer step: current line state and one byte in,
// next line state and one result out.
module qft_core (
   input  wire logic [7:0]           line_byte,
   input  wire logic [7:0]           line_end_char,
   input  wire qft_pkg::state_type   cur,
   output qft_pkg::state_type        nxt,
   output qft_pkg::result_type       res
);

   logic                      is_end;
   logic                      is_space;
   logic                      is_quote;
   logic                      too_long;
   logic                      err;
   logic                      full;
   logic [qft_pkg::OFF_W-1:0] off_adv;
   logic [qft_pkg::OFF_W-1:0] off_plus1;
   logic [qft_pkg::OFF_W-1:0] end_off;
   logic                      emit_try;
   logic                      finish;
   logic                      fin_err;

   // Byte classes and limits
   assign is_end    = (line_byte == line_end_char);
   assign is_space  = (line_byte == qft_pkg::SPACE_BYTE);
   assign is_quote  = (line_byte == qft_pkg::QUOTE_BYTE);
   assign too_long  = (cur.byte_offset >= qft_pkg::OFF_W'(qft_pkg::LINE_BYTES));
   assign err       = cur.error_seen | too_long;
   assign full      = (cur.fields_done >= qft_pkg::CNT_W'(qft_pkg::MAX_FIELDS));
   assign off_plus1 = cur.byte_offset + qft_pkg::OFF_W'(1);
   assign off_adv   = too_long ? cur.byte_offset : off_plus1;

   always_comb begin
      nxt             = cur;
      nxt.byte_offset = off_adv;
      res             = '0;
      emit_try        = 1'b0;
      end_off         = cur.byte_offset;
      finish          = 1'b0;
      fin_err         = 1'b0;

      // Byte classification, in priority order
      priority if (err) begin
         nxt.error_seen = 1'b1;
         finish         = is_end;
         fin_err        = 1'b1;
      end else if (cur.just_closed_quote) begin
         nxt.just_closed_quote = 1'b0;
         if (is_end || is_space) begin
            emit_try = 1'b1;
            end_off  = cur.byte_offset - qft_pkg::OFF_W'(1);
            finish   = is_end;
            nxt.field_start = off_plus1;
         end else begin
            nxt.error_seen = 1'b1;
         end
      end else if (is_quote) begin
         if (!cur.inside_quotes) begin
            nxt.inside_quotes = 1'b1;
            nxt.field_start   = off_plus1;
         end else begin
            nxt.inside_quotes     = 1'b0;
            nxt.just_closed_quote = 1'b1;
         end
      end else if (cur.inside_quotes) begin
         finish  = is_end;
         fin_err = 1'b1;
      end else if (is_end || is_space) begin
         emit_try        = 1'b1;
         finish          = is_end;
         nxt.field_start = off_plus1;
      end

      // Field report, or overflow once the line holds MAX_FIELDS fields
      if (emit_try) begin
         if (full) begin
            nxt.error_seen = 1'b1;
            fin_err        = 1'b1;
         end else begin
            res.field_valid  = 1'b1;
            res.field_index  = qft_pkg::fit_idx(cur.fields_done);
            res.field_start  = qft_pkg::fit_pos(cur.field_start);
            res.field_length = qft_pkg::fit_pos(end_off - cur.field_start);
            nxt.fields_done  = cur.fields_done + qft_pkg::CNT_W'(1);
         end
      end

      // Line end clears the line state
      if (finish) begin
         res.line_end   = 1'b1;
         res.line_error = fin_err;
         nxt            = '0;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/qft_checker.sv =====
`default_nettype none
`include "quoted_field_tokenizer_macros.svh"
// Port-level checks on the tokenizer.
module qft_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_field_valid,
   input wire logic [qft_pkg::IDX_W-1:0] rsp_field_index,
   input wire logic [qft_pkg::POS_W-1:0] rsp_field_start,
   input wire logic [qft_pkg::POS_W-1:0] rsp_field_length,
   input wire logic                      rsp_line_end,
   input wire logic                      rsp_line_error
);

   // No field reported: its index, start and length read zero
   `QFT_ASSERT_IMP(a_empty_field_zero, clock, reset, rsp_valid && !rsp_field_valid, rsp_field_index == '0 && rsp_field_start == '0 && rsp_field_length == '0)

   // An error flag only comes with a line end
   `QFT_ASSERT_IMP(a_error_with_end, clock, reset, rsp_valid && rsp_line_error, rsp_line_end)

   // Reset empties the result register
   `QFT_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // A stalled item stays put
   `QFT_ASSERT_NEXT(a_stall_hold, clock, !reset && rsp_valid && !rsp_ready, reset || (rsp_valid && $stable(rsp_field_length) && $stable(rsp_line_end)))

endmodule

bind quoted_field_tokenizer qft_checker u_qft_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_field_valid  (rsp_field_valid),
   .rsp_field_index  (rsp_field_index),
   .rsp_field_start  (rsp_field_start),
   .rsp_field_length (rsp_field_length),
   .rsp_line_end     (rsp_line_end),
   .rsp_line_error   (rsp_line_error)
);
`default_nettype wire

// ===== test/quoted_field_tokenizer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// line state and compares every accepted result item with the prediction.
module quoted_field_tokenizer_checker
   import qft_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [7:0]       req_line_byte,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_field_valid,
   input  logic [IDX_W-1:0] rsp_field_index,
   input  logic [POS_W-1:0] rsp_field_start,
   input  logic [POS_W-1:0] rsp_field_length,
   input  logic             rsp_line_end,
   input  logic             rsp_line_error,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data,
   output int               fail_count,
   output int               reports_pending,
   output int               lines_seen,
   output int               bad_lines_seen,
   output int               fields_seen
);

   // Shadow of the register and the per-line state
   logic [7:0]       end_byte;
   logic             in_quotes;
   logic             after_close;
   logic             line_bad;
   logic [OFF_W-1:0] offset;
   logic [OFF_W-1:0] field_begin;
   logic [CNT_W-1:0] fields_in_line;

   // One expected report per accepted byte, oldest first
   result_type byte_reports_q [$];

   int mismatches;
   int n_lines;
   int n_bad;
   int n_fields;

   function automatic void clear_line_state();
      in_quotes      = 1'b0;
      after_close    = 1'b0;
      line_bad       = 1'b0;
      offset         = '0;
      field_begin    = '0;
      fields_in_line = '0;
   endfunction

   function automatic void step_offset();
      if (offset < OFF_W'(LINE_BYTES))
         offset = offset + 1'b1;
   endfunction

   // Report the open field ending at end_off, unless the line already has
   // the maximum number of fields
   function automatic void report_field(inout result_type r, input logic [OFF_W-1:0] end_off);
      if (fields_in_line >= CNT_W'(MAX_FIELDS)) begin
         line_bad = 1'b1;
         return;
      end
      r.field_valid  = 1'b1;
      r.field_index  = IDX_W'(fields_in_line);
      r.field_start  = POS_W'(field_begin);
      r.field_length = POS_W'(end_off - field_begin);
      fields_in_line = fields_in_line + 1'b1;
   endfunction

   function automatic void close_line(inout result_type r);
      r.line_end   = 1'b1;
      r.line_error = line_bad;
      clear_line_state();
   endfunction

   // Advance the line state by one byte and return what the block reports
   function automatic result_type tokenize_byte(input logic [7:0] b);
      result_type r;
      logic       at_end;
      r      = '0;
      at_end = (b == end_byte);

      // overlong line
      if (offset >= OFF_W'(LINE_BYTES))
         line_bad = 1'b1;

      // a bad line only waits for its terminator
      if (line_bad) begin
         if (at_end)
            close_line(r);
         else
            step_offset();
         return r;
      end

      if (after_close) begin
         // byte after a closing quote: separator or terminator, else error
         after_close = 1'b0;
         if (at_end || b == SPACE_BYTE) begin
            report_field(r, offset - 1'b1);
            if (at_end) begin
               close_line(r);
               return r;
            end
            field_begin = offset + 1'b1;
         end else begin
            line_bad = 1'b1;
         end
      end else if (b == QUOTE_BYTE) begin
         // opening quote restarts the field after it
         if (!in_quotes) begin
            in_quotes   = 1'b1;
            field_begin = offset + 1'b1;
         end else begin
            in_quotes   = 1'b0;
            after_close = 1'b1;
         end
      end else if (in_quotes) begin
         if (at_end) begin
            line_bad = 1'b1;
            close_line(r);
            return r;
         end
      end else if (at_end || b == SPACE_BYTE) begin
         report_field(r, offset);
         if (at_end) begin
            close_line(r);
            return r;
         end
         field_begin = offset + 1'b1;
      end

      step_offset();
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   initial begin
      end_byte    = LINE_END_INIT;
      mismatches  = 0;
      n_lines     = 0;
      n_bad       = 0;
      n_fields    = 0;
      clear_line_state();
   end

   always @(posedge clock) begin
      result_type want;
      result_type predicted;
      if (reset) begin
         end_byte = LINE_END_INIT;
         clear_line_state();
         byte_reports_q.delete();
      end else begin
         if (csr_write_enable)
            end_byte = csr_write_data;

         // predict on every accepted byte
         if (req_valid && req_ready) begin
            predicted      = tokenize_byte(req_line_byte);
            byte_reports_q = {byte_reports_q, predicted};
         end

         // compare every accepted result item with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (byte_reports_q.size() == 0) begin
               $error("result item with no byte outstanding");
               mismatches++;
            end else begin
               want = byte_reports_q.pop_front();
               check_field("field_valid", 32'(want.field_valid), 32'(rsp_field_valid));
               check_field("field_index", 32'(want.field_index), 32'(rsp_field_index));
               check_field("field_start", 32'(want.field_start), 32'(rsp_field_start));
               check_field("field_length", 32'(want.field_length),
                           32'(rsp_field_length));
               check_field("line_end", 32'(want.line_end), 32'(rsp_line_end));
               check_field("line_error", 32'(want.line_error), 32'(rsp_line_error));
            end
            if (rsp_line_end === 1'b1)
               n_lines++;
            if (rsp_line_error === 1'b1)
               n_bad++;
            if (rsp_field_valid === 1'b1)
               n_fields++;
         end
      end

      // published after the edge so the stimulus side sees settled counts
      fail_count      <= mismatches;
      reports_pending <= byte_reports_q.size();
      lines_seen      <= n_lines;
      bad_lines_seen  <= n_bad;
      fields_seen     <= n_fields;
   end

endmodule

// ===== test/quoted_field_tokenizer_test.sv =====
`timescale 1ns / 1ps

module quoted_field_tokenizer_test;
   import qft_pkg::*;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [7:0]       req_line_byte;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_field_valid;
   logic [IDX_W-1:0] rsp_field_index;
   logic [POS_W-1:0] rsp_field_start;
   logic [POS_W-1:0] rsp_field_length;
   logic             rsp_line_end;
   logic             rsp_line_error;
   logic             csr_write_enable;
   logic [7:0]       csr_write_data;

   int fail_count;
   int reports_pending;
   int lines_seen;
   int bad_lines_seen;
   int fields_seen;

   // Stimulus-side view of the line-end byte and pacing controls
   logic [7:0] cur_line_end = LINE_END_INIT;
   bit         quiet = 1'b0;
   bit         long_hold_req = 1'b0;
   int         items_sent = 0;

   quoted_field_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line_byte    (req_line_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_valid  (rsp_field_valid),
      .rsp_field_index  (rsp_field_index),
      .rsp_field_start  (rsp_field_start),
      .rsp_field_length (rsp_field_length),
      .rsp_line_end     (rsp_line_end),
      .rsp_line_error   (rsp_line_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   quoted_field_tokenizer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line_byte    (req_line_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_valid  (rsp_field_valid),
      .rsp_field_index  (rsp_field_index),
      .rsp_field_start  (rsp_field_start),
      .rsp_field_length (rsp_field_length),
      .rsp_line_end     (rsp_line_end),
      .rsp_line_error   (rsp_line_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .reports_pending  (reports_pending),
      .lines_seen       (lines_seen),
      .bad_lines_seen   (bad_lines_seen),
      .fields_seen      (fields_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short idle spans, a few long ones
   function automatic int idle_span();
      if ($urandom_range(0, 99) < 75)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // A byte that is neither a quote nor the line end (nor a space unless allowed)
   function automatic logic [7:0] plain_byte(input bit spaces_ok);
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == QUOTE_BYTE || b == cur_line_end || (!spaces_ok && b == SPACE_BYTE));
      return b;
   endfunction

   // Offer one item and hold it until accepted
   task automatic send_byte(input logic [7:0] b);
      int  gap;
      bit  taken;
      gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_line_byte <= b;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic send_plain(input int n, input bit spaces_ok);
      repeat (n) send_byte(plain_byte(spaces_ok));
   endtask

   // Drop valid and wait until every byte has reported
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_line_end(input logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_line_end = v;
   endtask

   // Mostly well-formed lines with random content, otherwise broken lines or noise
   task automatic send_random_line();
      int kind;
      int nf;
      int k;
      kind  = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 7) == 0);
      if (kind < 70) begin
         nf = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
         for (k = 0; k < nf; k++) begin
            if (k > 0) begin
               send_byte(SPACE_BYTE);
               if ($urandom_range(0, 9) == 0)
                  send_byte(SPACE_BYTE);
            end
            if ($urandom_range(0, 2) == 0) begin
               send_byte(QUOTE_BYTE);
               send_plain($urandom_range(0, 6), 1'b1);
               send_byte(QUOTE_BYTE);
            end else begin
               send_plain((nf > 6) ? $urandom_range(0, 1) : $urandom_range(0, 6), 1'b0);
            end
         end
      end else if (kind < 85) begin
         case ($urandom_range(0, 2))
            0: begin
               // stray byte after a closing quote
               send_byte(QUOTE_BYTE);
               send_plain($urandom_range(0, 3), 1'b1);
               send_byte(QUOTE_BYTE);
               send_byte(plain_byte(1'b0));
               send_plain($urandom_range(0, 3), 1'b0);
            end
            1: begin
               // line ends inside quotes
               send_byte(QUOTE_BYTE);
               send_plain($urandom_range(0, 5), 1'b1);
            end
            default: begin
               // quote in the middle of a field
               send_plain($urandom_range(1, 3), 1'b0);
               send_byte(QUOTE_BYTE);
               send_plain($urandom_range(0, 3), 1'b0);
               send_byte(QUOTE_BYTE);
            end
         endcase
      end else begin
         nf = $urandom_range(1, 12);
         for (k = 0; k < nf; k++) begin
            case ($urandom_range(0, 3))
               0:       send_byte(SPACE_BYTE);
               1:       send_byte(QUOTE_BYTE);
               2:       send_byte(cur_line_end);
               default: send_byte(8'($urandom_range(0, 255)));
            endcase
         end
      end
      send_byte(cur_line_end);
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = 250;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (quiet || $urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall = idle_span() - 1;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic [7:0] opening [$];
      logic [7:0] line_ends [7];
      int         start;
      int         p;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_line_byte    <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty fields, quoted field with a space, stray byte after
      // a close, line end inside quotes, quote mid-field, byte extremes
      opening = {SPACE_BYTE, LINE_END_INIT,
                 QUOTE_BYTE, 8'h61, SPACE_BYTE, 8'h62, QUOTE_BYTE, SPACE_BYTE, 8'h63,
                 LINE_END_INIT,
                 QUOTE_BYTE, 8'h61, QUOTE_BYTE, 8'h78, LINE_END_INIT,
                 QUOTE_BYTE, LINE_END_INIT,
                 8'h61, QUOTE_BYTE, 8'h62, QUOTE_BYTE, SPACE_BYTE, LINE_END_INIT,
                 8'hFF, 8'h00, 8'h55, 8'hAA, LINE_END_INIT};
      foreach (opening[i])
         send_byte(opening[i]);

      // Exactly the maximum field count, then one line past it
      repeat (MAX_FIELDS - 1) send_byte(SPACE_BYTE);
      send_byte(LINE_END_INIT);
      repeat (MAX_FIELDS + 2) send_byte(SPACE_BYTE);
      send_byte(LINE_END_INIT);

      // Random lines under several line-end settings
      line_ends = '{LINE_END_INIT, 8'h00, 8'hFF, SPACE_BYTE, QUOTE_BYTE,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      for (p = 0; p < 7; p++) begin
         wait_idle();
         set_line_end(line_ends[p]);
         if (p == 1 || p == 4)
            long_hold_req = 1'b1;
         start = items_sent;
         while (items_sent - start < 80)
            send_random_line();
      end

      wait_idle();
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes: %0d lines ended (%0d flagged bad), %0d fields reported.",
               items_sent, lines_seen, bad_lines_seen, fields_seen);
      $display("Covered empty, quoted and broken fields, field-count overflow, long %s",
               "result stalls and seven line-end settings.");
      if (fail_count == 0 && reports_pending == 0)
         $display("quoted_field_tokenizer_test OK");
      else
         $display("quoted_field_tokenizer_test NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $error("run did not complete in time");
      $display("quoted_field_tokenizer_test NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qft_pkg.sv
rtl/qft_core.sv
rtl/quoted_field_tokenizer.sv
rtl/qft_checker.sv
test/quoted_field_tokenizer_checker.sv
test/quoted_field_tokenizer_test.sv
